// File: design/fcs_pkg.sv
// Shared constants and controller/datapath interface types for the saturating FIR core.
package fcs_pkg;

    localparam int TAPS_DEF      = 256;
    localparam int HIST_DEF      = 256;

    localparam int IDX_W         = 8;
    localparam int COEF_W        = 32;
    localparam int SAMPLE_W      = 16;
    localparam int PROD_W        = COEF_W + SAMPLE_W;
    localparam int ACC_W         = 32;
    localparam int SHIFT_W       = 5;
    localparam int IN_DATA_W     = 56;
    localparam int OUT_DATA_W    = 16;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;

    typedef struct packed {
        logic clear;         // write zero into the history and step the clear address
        logic load_coef;     // coefficient transfer accepted this cycle
        logic store_sample;  // sample transfer accepted this cycle
        logic issue;         // read one tap pair and step the tap counter
        logic scale;         // apply the doubling and tap-count multiply
        logic put;           // saturate and move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/fir_convolution_saturating_core.sv
// Top level of the saturating direct-form FIR core for cabinet simulation.
//
//  Channel  Dir  Handshake                 Content
//  s        in   i_s_tvalid / o_s_tready   tuser: cmd; tdata: tap_index, tap_value, pcm_in
//  m        out  o_m_tvalid / i_m_tready   tdata: pcm_out
//  cfg      in   i_cfg_we                  output_shift
//
// A coefficient transfer leaves the controller idle, so loads may follow each other every cycle.
// A sample transfer starts a walk in which the single shared MAC reads one coefficient and
// one history entry per cycle; the products then drain, the sum is scaled, and the saturated
// result is registered at the output before the next transfer is taken. After reset a
// clearing pass zeroes every history entry before any transfer is taken. A stalled sink
// holds back only the final output step, and the next item is taken while the previous
// result still waits in the output register.
module fir_convolution_saturating_core #(
    parameter int TAPS          = fcs_pkg::TAPS_DEF,
    parameter int HISTORY_DEPTH = fcs_pkg::HIST_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fcs_pkg::IN_DATA_W-1:0]    i_s_tdata,   // tap_index, tap_value, pcm_in
    input  logic                             i_s_tuser,   // cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [fcs_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // pcm_out
    input  logic                             i_cfg_we,
    input  logic [fcs_pkg::SHIFT_W-1:0]      i_cfg_wdata
);
    import fcs_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_cmd    (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fcs_datapath #(
        .TAPS          (TAPS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tap_index (i_s_tdata[7:0]),
        .i_tap_value (i_s_tdata[39:8]),
        .i_sample    (i_s_tdata[55:40]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// File: design/fcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fcs_datapath.sv
// Datapath: coefficient and history stores, MAC pipeline, scaling, saturation, output register.
module fcs_datapath #(
    parameter int TAPS          = fcs_pkg::TAPS_DEF,
    parameter int HISTORY_DEPTH = fcs_pkg::HIST_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fcs_pkg::t_dp_cmd                 i_cmd,
    output fcs_pkg::t_dp_stat                o_stat,
    input  logic [fcs_pkg::IDX_W-1:0]        i_tap_index,
    input  logic [fcs_pkg::COEF_W-1:0]       i_tap_value,
    input  logic [fcs_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_cfg_we,
    input  logic [fcs_pkg::SHIFT_W-1:0]      i_cfg_wdata,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [fcs_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import fcs_pkg::*;

    localparam int CW = $clog2(TAPS);
    localparam int HW = $clog2(HISTORY_DEPTH);

    logic [SHIFT_W-1:0]     r_shift;
    logic [HW-1:0]          r_clr_addr;
    logic [HW-1:0]          r_head;
    logic [HW-1:0]          r_ptr;
    logic [CW-1:0]          r_k;
    logic                   r_v1;
    logic                   r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       r_scaled;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic [COEF_W-1:0]      w_coef_q;
    logic [SAMPLE_W-1:0]    w_hist_q;
    logic                   w_coef_we;
    logic [CW-1:0]          w_coef_waddr;
    logic                   w_hist_we;
    logic [HW-1:0]          w_hist_waddr;
    logic [SAMPLE_W-1:0]    w_hist_wdata;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]       w_dbl;
    logic [ACC_W-1:0]       w_taps_k;
    logic signed [ACC_W-1:0] w_shifted;
    logic [OUT_DATA_W-1:0]  w_sat;
    logic                   w_out_free;
    logic                   w_put_done;

    // Loads with an index at or beyond the tap count are dropped.
    assign w_coef_we    = i_cmd.load_coef && (32'(i_tap_index) < TAPS);
    assign w_coef_waddr = CW'(i_tap_index);

    assign w_hist_we    = i_cmd.clear || i_cmd.store_sample;
    assign w_hist_waddr = i_cmd.clear ? r_clr_addr : r_head;
    assign w_hist_wdata = i_cmd.clear ? '0 : i_sample;

    fcs_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (i_tap_value),
        .i_raddr (r_k),
        .o_rdata (w_coef_q)
    );

    fcs_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_hist_q)
    );

    assign w_prod   = $signed(w_coef_q) * $signed(w_hist_q);
    assign w_dbl    = {r_acc[ACC_W-2:0], 1'b0};
    assign w_taps_k = ACC_W'(TAPS);

    // Floor division by a power of two, then clip to the 16-bit signed range.
    assign w_shifted = $signed(r_scaled) >>> r_shift;
    always_comb begin
        if (w_shifted > 32'sd32767) begin
            w_sat = 16'h7fff;
        end else if (w_shifted < -32'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_shifted[OUT_DATA_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_put_done = i_cmd.put && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= SHIFT_RESET;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_put_done) begin
                r_head <= (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (w_put_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_sample) begin
            r_k   <= '0;
            r_ptr <= r_head;
            r_acc <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_k   <= r_k + 1'b1;
                r_ptr <= (r_ptr == '0) ? HW'(HISTORY_DEPTH - 1) : r_ptr - 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod >>> 16);
            end
        end
        if (r_v1) begin
            r_prod <= w_prod;
        end
        if (i_cmd.scale) begin
            r_scaled <= w_dbl * w_taps_k;
        end
        if (w_put_done) begin
            r_out_data <= w_sat;
        end
    end

    assign o_stat.clr_last  = (r_clr_addr == HW'(HISTORY_DEPTH - 1));
    assign o_stat.tap_last  = (r_k == CW'(TAPS - 1));
    assign o_stat.pipe_busy = r_v1 || r_v2;
    assign o_stat.out_free  = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A new sample restarts the tap walk at the newest history slot.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_sample |=> (r_k == '0) && (r_ptr == $past(r_head)))
        else $error("tap walk did not start at the head");

    // A result waiting for the sink is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid && $stable(r_out_data))
        else $error("pending result changed before its transfer");

    // The head moves exactly when a result is delivered to the output register.
    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_put_done |=> $stable(r_head))
        else $error("head moved without a result");
`endif

endmodule

// File: design/fcs_ctrl.sv
// Controller: sequences clearing, item acceptance, the MAC walk, scaling and output.
module fcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_cmd,
    output logic               o_s_tready,
    input  fcs_pkg::t_dp_stat  i_stat,
    output fcs_pkg::t_dp_cmd   o_cmd
);
    import fcs_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_cmd == CMD_SAMPLE) begin
                        o_cmd.store_sample = 1'b1;
                        n_state            = S_RUN;
                    end else begin
                        o_cmd.load_coef = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_PUT;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // The sum is scaled only after the last product has been accumulated.
    a_scale_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> !i_stat.pipe_busy)
        else $error("scaling started with products still in flight");

    // The walk leaves the run state right after issuing the last tap.
    a_run_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_stat.tap_last) |=> (r_state == S_DRAIN) && i_stat.pipe_busy)
        else $error("tap walk did not end at the last tap");

    // No read of the stores is issued while clearing or waiting on the sink.
    a_issue_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> !o_cmd.put && !o_cmd.clear && !o_s_tready)
        else $error("tap read issued outside the walk");
`endif

endmodule

// File: test/fcs_output_checker.sv
`timescale 1ns / 100ps
// Watches the FIR core's channels, predicts every filtered sample and compares it on arrival.
module fcs_output_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [fcs_pkg::IN_DATA_W-1:0]    i_s_tdata,   // tap_index, tap_value, pcm_in
    input  logic                             i_s_tuser,   // cmd
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [fcs_pkg::OUT_DATA_W-1:0]   i_m_tdata,   // pcm_out
    input  logic                             i_cfg_we,
    input  logic [fcs_pkg::SHIFT_W-1:0]      i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    localparam int TAPS = fcs_pkg::TAPS_DEF;
    localparam int HIST = fcs_pkg::HIST_DEF;

    logic signed [31:0]      tap_bank [TAPS];
    logic signed [15:0]      sample_ring [HIST];
    int                      ring_head;
    logic [4:0]              shift_amt;
    logic [15:0]             expected_samples [$];
    int                      fails;

    // Runs the whole convolution for the sample that was just written at the ring head.
    function automatic logic [15:0] filter_next_sample();
        logic [31:0] acc;
        longint      prod;
        longint      scaled;
        int          ptr;
        acc = '0;
        ptr = ring_head;
        for (int k = 0; k < TAPS; k++) begin
            prod = longint'(tap_bank[k]) * longint'(sample_ring[ptr]);
            acc  = acc + 32'(prod >>> 16);
            ptr  = (ptr == 0) ? HIST - 1 : ptr - 1;
        end
        // The doubling and the tap-count scaling both wrap at 32 bits.
        acc    = (acc << 1) * 32'(TAPS);
        scaled = longint'($signed(acc)) >>> shift_amt;
        if (scaled > 32767) begin
            return 16'h7FFF;
        end
        if (scaled < -32768) begin
            return 16'h8000;
        end
        return 16'(scaled);
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] want;
        logic [7:0]  idx;
        if (!i_rst_n) begin
            shift_amt = fcs_pkg::SHIFT_RESET;
            ring_head = 0;
            fails     = 0;
            for (int i = 0; i < HIST; i++) begin
                sample_ring[i] = '0;
            end
            for (int i = 0; i < TAPS; i++) begin
                tap_bank[i] = '0;
            end
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                shift_amt = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == fcs_pkg::CMD_LOAD) begin
                    idx = i_s_tdata[7:0];
                    tap_bank[idx] = i_s_tdata[39:8];
                end else begin
                    sample_ring[ring_head] = i_s_tdata[55:40];
                    expected_samples.push_back(filter_next_sample());
                    ring_head = (ring_head == HIST - 1) ? 0 : ring_head + 1;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected output transfer, pcm_out %0d", $signed(i_m_tdata));
                    fails++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("pcm_out mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(i_m_tdata));
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_samples.size();
    end

endmodule

// File: test/fir_convolution_saturating_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the saturating FIR core: stimulus, handshake idling and the verdict.
module fir_convolution_saturating_core_tb;
    import fcs_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = TAPS_DEF + 16;
    localparam int IDLE_PCT      = 37;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 70;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [SHIFT_W-1:0]     cfg_wdata = SHIFT_RESET;

    logic                   quiet     = 1'b0;
    logic                   hold_go   = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_cnt  = 0;
    int                     cycle_count = 0;
    int                     fail_count;
    int                     pending;

    fir_convolution_saturating_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    fcs_output_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fir_convolution_saturating_core verification failed");
            $finish;
        end
    end

    // Output side: random backpressure, plus one long hold-off so the core backs up.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_go && !hold_done) begin
            m_tready  <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] idx,
                             input logic [31:0] tap, input logic [15:0] smp);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {smp, tap, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // The unused fields of each transfer carry random noise.
    task automatic load_coef(input logic [7:0] idx, input logic [31:0] tap);
        send_item(CMD_LOAD, idx, tap, 16'($urandom()));
    endtask

    task automatic push_sample(input logic [15:0] smp);
        send_item(CMD_SAMPLE, 8'($urandom()), $urandom(), smp);
    endtask

    // Waits until every filtered sample has come out and any load has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_tap(input int mag);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom();
            default: return 32'($signed($urandom()) >>> mag);
        endcase
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int mag;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_shift(SHIFT_RESET);

        // Every coefficient must hold a known value before the first sample.
        for (int i = 0; i < TAPS_DEF; i++) begin
            load_coef(8'(i), 32'h0);
        end

        // Full-scale taps against full-scale samples; the most negative pair wraps the sum.
        load_coef(8'd0, 32'h7FFF_FFFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        load_coef(8'd0, 32'h8000_0000);
        push_sample(16'h8000);
        push_sample(16'h0000);
        load_coef(8'd255, 32'hFFFF_FFFF);
        load_coef(8'd1, 32'h0000_0001);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        load_coef(8'd0, 32'h0000_1000);
        push_sample(16'd12345);

        settle();
        write_shift(5'd0);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(16'd100);
        settle();
        write_shift(5'd31);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_shift((p == 0) ? SHIFT_RESET : 5'($urandom_range(0, 31)));
            mag = $urandom_range(4, 28);
            quiet <= (p == 3);
            if (p == 5) begin
                hold_go <= 1'b1;
            end
            if (p % 3 == 0) begin
                for (int i = 0; i < TAPS_DEF; i++) begin
                    load_coef(8'(i), rand_tap(mag));
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 45) begin
                    load_coef(8'($urandom_range(0, 255)), rand_tap(mag));
                end else begin
                    push_sample(rand_sample());
                end
            end
        end

        quiet <= 1'b0;
        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("fir_convolution_saturating_core verification clean");
        end else begin
            $display("fir_convolution_saturating_core verification failed");
        end
        $finish;
    end

endmodule
